/* sv/fapr_pkg.sv */
// shared types and constants of the framed angle packet receiver
// no dependencies; imported by every module of the block
package fapr_pkg;

  // frame geometry: header, yaw (4), pitch (4), flag, tail
  localparam int unsigned FrameLen = 11;
  localparam int unsigned StoreLen = 9;   // bytes 1..9 are kept, header and tail are not
  localparam int unsigned FillW    = 4;
  localparam logic [FillW-1:0] LastPos = FillW'(FrameLen - 1);

  // command queue between the front and back parts
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // register map
  localparam logic [1:0] RegHeader     = 2'd0;
  localparam logic [1:0] RegTail       = 2'd1;
  localparam logic [1:0] RegPitchLimit = 2'd2;
  localparam logic [1:0] RegYawLimit   = 2'd3;

  localparam logic [30:0] PitchLimitReset = 31'h42B4_0000;  // 90.0
  localparam logic [30:0] YawLimitReset   = 31'h43B4_0000;  // 360.0

  typedef enum logic {
    OP_RECEIVE = 1'b0,
    OP_CLEAR   = 1'b1
  } op_e;

  typedef struct packed {
    logic [7:0]  header;
    logic [7:0]  tail;
    logic [30:0] pitch_limit;
    logic [30:0] yaw_limit;
  } cfg_t;

  // one command from the front: a clear, or a completed frame with its verdict
  typedef struct packed {
    op_e         kind;
    logic        ok;
    logic [31:0] yaw;
    logic [31:0] pitch;
    logic        flag;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] yaw;
    logic [31:0] pitch;
    logic        flag;
    logic [31:0] count;
  } result_t;

endpackage

/* sv/framed_angle_packet_receiver_core.sv */
// top level of the framed angle packet receiver: config registers and wiring
// depends on fapr_pkg, fapr_front, fapr_queue and fapr_back
//
// usage
// - slave channel: one beat per received byte (tdata) or clear command (tuser set)
// - the front hunts for the header byte, collects an 11-byte frame and checks
//   tail, finiteness and magnitude limits when the last byte arrives
// - a completed frame gives one master beat: verdict in tuser, held yaw,
//   pitch, flag and the accepted-frame count in tdata; other beats give none
// - a clear zeroes the held target in order with frames, without a result
// - throughput: one byte per cycle while the command queue is not full, set by
//   the combinational frame check in the front and the pop of the back part
// - path of a frame: the edge that takes its final byte pushes its command
//   into the queue, and the back part pops it into the result register once
//   that register is free; the beat is valid from then on
// - a two-entry command queue parts front and back; while the master side
//   stalls, bytes still flow until the queue holds two pending commands,
//   then s_tready_o drops
// - reset clears the framing state, held target, counter, queue and output
//   valid; the registers return to header 0, tail 0, limits 90.0 and 360.0
// - config writes take effect at the next edge and belong in idle periods
module framed_angle_packet_receiver_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave side
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [7:0]   s_tdata_i,   // [7:0] data_byte
  input  logic         s_tuser_i,   // [0] operation
  // master side
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [103:0] m_tdata_o,   // [31:0] yaw_bits, [63:32] pitch_bits,
                                    // [64] target_flag, [96:65] frame_count, rest zero
  output logic         m_tuser_o,   // [0] frame_ok
  // configuration
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_index_i,
  input  logic [30:0]  cfg_data_i
);
  import fapr_pkg::*;

  cfg_t    cfg_q;
  logic    push;
  entry_t  push_entry;
  entry_t  q_entry;
  q_stat_t q_stat;
  logic    pop;
  result_t result;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header      <= 8'd0;
      cfg_q.tail        <= 8'd0;
      cfg_q.pitch_limit <= PitchLimitReset;
      cfg_q.yaw_limit   <= YawLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegHeader:     cfg_q.header      <= cfg_data_i[7:0];
        RegTail:       cfg_q.tail        <= cfg_data_i[7:0];
        RegPitchLimit: cfg_q.pitch_limit <= cfg_data_i;
        RegYawLimit:   cfg_q.yaw_limit   <= cfg_data_i;
        default:       cfg_q             <= cfg_q;
      endcase
    end
  end

  // front: framing and checking
  fapr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_tvalid_i),
    .in_ready_o   (s_tready_o),
    .in_op_i      (s_tuser_i),
    .in_byte_i    (s_tdata_i),
    .q_full_i     (q_stat.full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // commands in arrival order
  fapr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (q_entry),
    .stat_o  (q_stat)
  );

  // back: held target and results
  fapr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (q_entry),
    .empty_i     (q_stat.empty),
    .pop_o       (pop),
    .out_valid_o (m_tvalid_o),
    .out_ready_i (m_tready_i),
    .out_o       (result)
  );

  assign m_tuser_o = result.ok;
  assign m_tdata_o = {7'd0, result.count, result.flag, result.pitch, result.yaw};

  // queue can never be full and empty at once
  a_q_stat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_stat.full && q_stat.empty))
    else $error("queue status inconsistent");

  // the front only pushes when the queue has room
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_stat.full)
    else $error("push into full queue");

  // a clear drained behind a stalled result leaves that result alone
  a_clear_keeps_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && q_entry.kind == OP_CLEAR && m_tvalid_o && !m_tready_i)
      |=> $stable(m_tdata_o))
    else $error("clear disturbed pending beat");

endmodule

/* sv/fapr_front.sv */
// front part: header hunt, frame assembly and frame checking
// depends on fapr_pkg; pushes commands into fapr_queue
module fapr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fapr_pkg::cfg_t  cfg_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            in_op_i,
  input  logic [7:0]      in_byte_i,
  input  logic            q_full_i,
  output logic            push_o,
  output fapr_pkg::entry_t push_entry_o
);
  import fapr_pkg::*;

  function automatic logic angle_ok(input logic [31:0] bits, input logic [30:0] limit);
    angle_ok = (bits[30:23] != 8'hFF) && (bits[30:0] <= limit);
  endfunction

  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]       store_q [StoreLen];
  logic [FillW-1:0] store_idx;
  logic             store_we;
  logic             accept;
  op_e              op;
  logic [31:0]      yaw_w, pitch_w;
  logic             flag_w, is_hdr, frame_ok;

  assign in_ready_o = ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;
  assign op         = op_e'(in_op_i);
  assign store_idx  = fill_q - FillW'(1);

  assign yaw_w   = {store_q[3], store_q[2], store_q[1], store_q[0]};
  assign pitch_w = {store_q[7], store_q[6], store_q[5], store_q[4]};
  assign flag_w  = (store_q[8] != 8'd0);
  assign is_hdr  = (in_byte_i == cfg_i.header);

  assign frame_ok = (in_byte_i == cfg_i.tail)
                 && angle_ok(pitch_w, cfg_i.pitch_limit)
                 && angle_ok(yaw_w, cfg_i.yaw_limit);

  always_comb begin
    fill_d   = fill_q;
    push_o   = 1'b0;
    store_we = 1'b0;
    if (accept && op == OP_CLEAR) begin
      push_o = 1'b1;
    end else if (accept) begin
      priority if (fill_q == LastPos) begin
        // final byte: check and resync, reusing a header-valued byte of a failed frame
        push_o = 1'b1;
        fill_d = (!frame_ok && is_hdr) ? FillW'(1) : FillW'(0);
      end else if (fill_q != FillW'(0) && fill_q < LastPos) begin
        store_we = 1'b1;
        fill_d   = fill_q + FillW'(1);
      end else begin
        // hunting, out-of-range index behaves the same
        fill_d = is_hdr ? FillW'(1) : FillW'(0);
      end
    end
  end

  assign push_entry_o.kind  = op;
  assign push_entry_o.ok    = frame_ok;
  assign push_entry_o.yaw   = yaw_w;
  assign push_entry_o.pitch = pitch_w;
  assign push_entry_o.flag  = flag_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[store_idx] <= in_byte_i;
    end
  end

endmodule

/* sv/fapr_queue.sv */
// short command queue parting the front and back parts
// depends on fapr_pkg
module fapr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fapr_pkg::entry_t  entry_i,
  input  logic              pop_i,
  output fapr_pkg::entry_t  entry_o,
  output fapr_pkg::q_stat_t stat_o
);
  import fapr_pkg::*;

  entry_t           mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    ptr_inc = (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i & ~stat_o.full;
  assign do_pop       = pop_i & ~stat_o.empty;
  assign entry_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* sv/fapr_back.sv */
// back part: held target, accepted-frame counter and result register
// depends on fapr_pkg; drains fapr_queue
module fapr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fapr_pkg::entry_t  entry_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fapr_pkg::result_t out_o
);
  import fapr_pkg::*;

  logic [31:0] yaw_q, yaw_d, pitch_q, pitch_d, count_q, count_d;
  logic        flag_q, flag_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;
  logic        is_clear;

  assign is_clear = (entry_i.kind == OP_CLEAR);
  // a clear needs no result slot, a frame needs the output register free
  assign pop_o    = ~empty_i & (is_clear | ~out_valid_q | out_ready_i);

  always_comb begin
    yaw_d       = yaw_q;
    pitch_d     = pitch_q;
    flag_d      = flag_q;
    count_d     = count_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    if (pop_o && is_clear) begin
      yaw_d   = '0;
      pitch_d = '0;
      flag_d  = 1'b0;
    end else if (pop_o) begin
      if (entry_i.ok) begin
        yaw_d   = entry_i.yaw;
        pitch_d = entry_i.pitch;
        flag_d  = entry_i.flag;
        count_d = count_q + 32'd1;
      end
      out_valid_d = 1'b1;
      out_d.ok    = entry_i.ok;
      out_d.yaw   = yaw_d;
      out_d.pitch = pitch_d;
      out_d.flag  = flag_d;
      out_d.count = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q       <= '0;
      pitch_q     <= '0;
      flag_q      <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      yaw_q       <= yaw_d;
      pitch_q     <= pitch_d;
      flag_q      <= flag_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
